### src/tvtc_pkg.sv
package tvtc_pkg;

	localparam int WORD_COUNT = 8;
	localparam int WORD_MAX   = 5;

	// result codes
	localparam logic [2:0] TYPE_NULL   = 3'd0;
	localparam logic [2:0] TYPE_BOOL   = 3'd1;
	localparam logic [2:0] TYPE_INT    = 3'd2;
	localparam logic [2:0] TYPE_FLOAT  = 3'd3;
	localparam logic [2:0] TYPE_STRING = 3'd4;

	// integer recogniser phases
	localparam logic [1:0] IP_START  = 2'd0;
	localparam logic [1:0] IP_SIGN   = 2'd1;
	localparam logic [1:0] IP_DIGITS = 2'd2;
	localparam logic [1:0] IP_REJECT = 2'd3;

	// real number recogniser phases
	localparam logic [2:0] RP_START      = 3'd0;
	localparam logic [2:0] RP_MANT       = 3'd1;
	localparam logic [2:0] RP_EXP_START  = 3'd2;
	localparam logic [2:0] RP_EXP_SIGN   = 3'd3;
	localparam logic [2:0] RP_EXP_DIGITS = 3'd4;
	localparam logic [2:0] RP_REJECT     = 3'd5;

	// word order: null, nil, true, false, yes, no, 1, 0
	localparam logic [0:WORD_COUNT-1][0:WORD_MAX-1][7:0] WORD_TEXT = '{
		'{"n", "u", "l", "l", 8'h00},
		'{"n", "i", "l", 8'h00, 8'h00},
		'{"t", "r", "u", "e", 8'h00},
		'{"f", "a", "l", "s", "e"},
		'{"y", "e", "s", 8'h00, 8'h00},
		'{"n", "o", 8'h00, 8'h00, 8'h00},
		'{"1", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"0", 8'h00, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [0:WORD_COUNT-1][2:0] WORD_LEN = '{
		3'd4, 3'd3, 3'd4, 3'd5, 3'd3, 3'd2, 3'd1, 3'd1
	};

	typedef struct packed {
		logic                  skipping_blanks;
		logic                  text_ended;
		logic [2:0]            seen_count;
		logic [WORD_COUNT-1:0] keyword_alive;
		logic [1:0]            integer_phase;
		logic [2:0]            real_phase;
		logic                  seen_digit;
		logic                  seen_dot;
	} tvtc_state_t;

	localparam tvtc_state_t STATE_RESET = '{
		skipping_blanks: 1'b1,
		text_ended:      1'b0,
		seen_count:      3'd0,
		keyword_alive:   {WORD_COUNT{1'b1}},
		integer_phase:   IP_START,
		real_phase:      RP_START,
		seen_digit:      1'b0,
		seen_dot:        1'b0
	};

endpackage

### src/tvtc_ifs.sv
interface tvtc_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       has_byte;
	logic       last_byte;

	modport source (output valid, text_byte, has_byte, last_byte, input ready);
	modport sink (input valid, text_byte, has_byte, last_byte, output ready);
endinterface

interface tvtc_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] type_code;

	modport source (output valid, type_code, input ready);
	modport sink (input valid, type_code, output ready);
endinterface

### src/text_value_type_classifier.sv
// Text value type classifier.
// The text channel carries one byte of a text field per item, with has_byte
// marking a real byte (clear only for empty text) and last_byte closing the
// field. For each item with last_byte set, one item leaves on the result
// channel with type_code: 0 null, 1 bool, 2 int, 3 float, 4 string.
// Items without last_byte produce nothing.
// Every text item is registered, then classified by a short block of logic
// into the result register: result.valid rises when the last item of a text
// leaves the input register. One item is taken every cycle while text.ready holds.
// When the receiver stalls, the result register holds its type code. Items
// that are not last keep flowing; a last item waits in the input register
// until the result register is free, and text.ready then drops.
// Reset clears both registers' valid flags and returns the scan state to
// the start of a text, as does each last item.
module text_value_type_classifier (
	input  logic             clk,
	input  logic             arst_n,
	tvtc_text_if.sink        text,
	tvtc_result_if.source    result
);
	import tvtc_pkg::*;

	logic        valid_s1;
	logic [7:0]  text_byte_s1;
	logic        has_byte_s1;
	logic        last_byte_s1;
	tvtc_state_t state_q;
	tvtc_state_t state_nxt;
	logic [2:0]  code_nxt;
	logic        out_valid_q;
	logic [2:0]  type_code_q;
	logic        advance;

	assign advance    = valid_s1 && (!last_byte_s1 || !out_valid_q || result.ready);
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			text_byte_s1 <= text.text_byte;
			has_byte_s1  <= text.has_byte;
			last_byte_s1 <= text.last_byte;
		end
	end

	tvtc_step u_step (
		.cur       (state_q),
		.text_byte (text_byte_s1),
		.has_byte  (has_byte_s1),
		.nxt       (state_nxt),
		.type_code (code_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= last_byte_s1 ? STATE_RESET : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_byte_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_byte_s1) begin
			type_code_q <= code_nxt;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.type_code = type_code_q;

endmodule

### src/tvtc_step.sv
module tvtc_step (
	input  tvtc_pkg::tvtc_state_t cur,
	input  logic [7:0]            text_byte,
	input  logic                  has_byte,
	output tvtc_pkg::tvtc_state_t nxt,
	output logic [2:0]            type_code
);
	import tvtc_pkg::*;

	logic [7:0]            folded;
	logic                  blank;
	logic                  digit;
	logic                  sign;
	logic [WORD_COUNT-1:0] hit;

	assign folded = (text_byte >= "A" && text_byte <= "Z") ? text_byte + 8'd32 : text_byte;
	assign blank  = (text_byte == 8'd32) || (text_byte >= 8'd9 && text_byte <= 8'd13);
	assign digit  = (text_byte >= "0") && (text_byte <= "9");
	assign sign   = (text_byte == "+") || (text_byte == "-");

	always_comb begin
		nxt = cur;
		if (has_byte && !cur.text_ended) begin
			if (text_byte == 8'h00) begin
				nxt.text_ended = 1'b1;
			end else if (!(cur.skipping_blanks && blank)) begin
				nxt.skipping_blanks = 1'b0;

				for (int k = 0; k < WORD_COUNT; k++) begin
					if (cur.seen_count >= WORD_LEN[k]) begin
						nxt.keyword_alive[k] = 1'b0;
					end else if (WORD_TEXT[k][cur.seen_count] != folded) begin
						nxt.keyword_alive[k] = 1'b0;
					end
				end
				if (cur.seen_count != 3'd7) begin
					nxt.seen_count = cur.seen_count + 3'd1;
				end

				case (cur.integer_phase) inside
					IP_START: begin
						if (sign) nxt.integer_phase = IP_SIGN;
						else if (digit) nxt.integer_phase = IP_DIGITS;
						else nxt.integer_phase = IP_REJECT;
					end
					IP_SIGN, IP_DIGITS: begin
						nxt.integer_phase = digit ? IP_DIGITS : IP_REJECT;
					end
					default: begin
					end
				endcase

				// a leading sign only opens the mantissa
				if (cur.real_phase == RP_START && sign) begin
					nxt.real_phase = RP_MANT;
				end else begin
					case (cur.real_phase) inside
						RP_START, RP_MANT: begin
							nxt.real_phase = RP_MANT;
							if (digit) nxt.seen_digit = 1'b1;
							else if (text_byte == "." && !cur.seen_dot) nxt.seen_dot = 1'b1;
							else if ((text_byte == "e" || text_byte == "E") && cur.seen_digit)
								nxt.real_phase = RP_EXP_START;
							else nxt.real_phase = RP_REJECT;
						end
						RP_EXP_START: begin
							if (sign) nxt.real_phase = RP_EXP_SIGN;
							else nxt.real_phase = digit ? RP_EXP_DIGITS : RP_REJECT;
						end
						RP_EXP_SIGN, RP_EXP_DIGITS: begin
							nxt.real_phase = digit ? RP_EXP_DIGITS : RP_REJECT;
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < WORD_COUNT; k++) begin
			hit[k] = nxt.keyword_alive[k] && (nxt.seen_count == WORD_LEN[k]);
		end
	end

	always_comb begin
		if (nxt.seen_count == 3'd0 || hit[0] || hit[1]) begin
			type_code = TYPE_NULL;
		end else if (|hit[WORD_COUNT-1:2]) begin
			type_code = TYPE_BOOL;
		end else if (nxt.integer_phase == IP_DIGITS) begin
			type_code = TYPE_INT;
		end else if (nxt.real_phase == RP_EXP_DIGITS ||
		             (nxt.real_phase == RP_MANT && nxt.seen_digit && nxt.seen_dot)) begin
			type_code = TYPE_FLOAT;
		end else begin
			type_code = TYPE_STRING;
		end
	end

endmodule

### src/tvtc_checker.sv
module tvtc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       text_valid,
	input logic       text_ready,
	input logic       text_last,
	input logic       result_valid,
	input logic       result_ready,
	input logic [2:0] type_code
);
	import tvtc_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(type_code))
		else $error("result changed while stalled");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> type_code <= TYPE_STRING)
		else $error("type code out of range");

	// the last item passes through the input register before its result shows
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(text_valid && text_ready && text_last, 2))
		else $error("result without a last item");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> text_ready)
		else $error("text stalled while result register empty");

endmodule

bind text_value_type_classifier tvtc_checker u_tvtc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.text_valid   (text.valid),
	.text_ready   (text.ready),
	.text_last    (text.last_byte),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.type_code    (result.type_code)
);
